[hdl/lrfp_pkg.sv]
// Shared constants and types for the lidar range frame parser.
package lrfp_pkg;

	// Frame layout bytes
	localparam logic [7:0] HDR_BYTE  = 8'hA5;
	localparam logic [7:0] DEV_BYTE  = 8'h03;
	localparam logic [7:0] TYPE_BYTE = 8'h20;
	localparam logic [7:0] MEAS_CMD  = 8'h01;

	localparam int MAX_PAYLOAD_DEF = 30;
	localparam int MIN_MEAS_LEN    = 14;
	localparam int HEAD_LEN        = 7;
	localparam int TAIL_LEN        = 2;

	// Fixed positions within the frame header
	localparam int POS_HDR  = 0;
	localparam int POS_DEV  = 1;
	localparam int POS_TYPE = 2;
	localparam int POS_CMD  = 3;
	localparam int POS_RSVD = 4;
	localparam int POS_LENH = 5;
	localparam int POS_LENL = 6;

	// Payload offsets of the measurement fields
	localparam int CENT_LO_OFS = 6;
	localparam int CENT_HI_OFS = 7;
	localparam int INTS_LO_OFS = 10;
	localparam int INTS_HI_OFS = 11;

	localparam int RAW_W  = 16;
	localparam int DIST_W = 13;
	localparam int STR_W  = 16;
	localparam int MAXD_W = 16;
	localparam int OUT_W  = 32;

	localparam logic [RAW_W-1:0]  RAW_INVALID  = 16'hFFFF;
	localparam logic [MAXD_W-1:0] MAX_DIST_RST = 16'd2000;
	localparam int                DIST_LIMIT   = 6553;

	// floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	typedef struct packed {
		logic              emit;
		logic [RAW_W-1:0]  raw;
		logic [STR_W-1:0]  strength;
	} frame_evt_t;

endpackage

[hdl/lidar_range_frame_parser_unit.sv]
// A byte accepted into the input register reaches the result register once that register is free.
// Throughput: one byte per cycle while the result register is empty or being read; the frame state
// updates from the input register, and the result register frees the input side.
// A result is produced only on the last byte of a measurement frame.
// Reset (arst_n low) clears the frame position, captured fields and both
// valid flags, and sets max_distance_cm to 2000.
module lidar_range_frame_parser_unit
	import lrfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [0] valid_res, [13:1] distance_cm, [29:14] strength
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MAXD_W-1:0] cfg_data   // [15:0] max_distance_cm
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_free;
	logic              fire;
	logic [MAXD_W-1:0] max_dist_q;
	frame_evt_t        evt;

	assign out_free  = !m_tvalid || m_tready;
	assign fire      = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= MAX_DIST_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_dist_q <= cfg_data;
		end
	end

	lrfp_frame_tracker #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire),
		.rx_byte (byte_s1),
		.evt     (evt)
	);

	lrfp_range_out u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.evt      (evt),
		.max_dist (max_dist_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

[hdl/lrfp_frame_tracker.sv]
// Frame position tracking and capture of the measurement fields.
module lrfp_frame_tracker
	import lrfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output frame_evt_t evt
);

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int POS_W = $clog2(MAX_PAYLOAD + HEAD_LEN + TAIL_LEN);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [RAW_W-1:0] cent_q, cent_d;
	logic [STR_W-1:0] ints_q, ints_d;
	logic [POS_W:0]   total;
	logic [POS_W:0]   pos_next;

	assign total    = (POS_W+1)'(HEAD_LEN + TAIL_LEN) + (POS_W+1)'(len_q);
	assign pos_next = {1'b0, pos_q} + (POS_W+1)'(1);

	always_comb begin
		pos_d        = pos_q;
		cmd_d        = cmd_q;
		len_hi_d     = len_hi_q;
		len_d        = len_q;
		cent_d       = cent_q;
		ints_d       = ints_q;
		evt.emit     = 1'b0;
		evt.raw      = cent_q;
		evt.strength = ints_q;
		if (step) begin
			case (pos_q)
				POS_W'(POS_HDR): begin
					if (rx_byte == HDR_BYTE)
						pos_d = POS_W'(POS_DEV);
				end
				POS_W'(POS_DEV): begin
					pos_d = (rx_byte == DEV_BYTE) ? POS_W'(POS_TYPE) : POS_W'(POS_HDR);
				end
				POS_W'(POS_TYPE): begin
					pos_d = (rx_byte == TYPE_BYTE) ? POS_W'(POS_CMD) : POS_W'(POS_HDR);
				end
				POS_W'(POS_CMD): begin
					cmd_d = rx_byte;
					pos_d = POS_W'(POS_RSVD);
				end
				POS_W'(POS_RSVD): begin
					pos_d = POS_W'(POS_LENH);
				end
				POS_W'(POS_LENH): begin
					len_hi_d = rx_byte;
					pos_d    = POS_W'(POS_LENL);
				end
				POS_W'(POS_LENL): begin
					if (len_hi_q != 8'd0 || rx_byte == 8'd0 || rx_byte > 8'(MAX_PAYLOAD)) begin
						pos_d = POS_W'(POS_HDR);
					end else begin
						len_d = LEN_W'(rx_byte);
						pos_d = POS_W'(HEAD_LEN);
					end
				end
				default: begin
					if (pos_q == POS_W'(HEAD_LEN + CENT_LO_OFS))
						cent_d[7:0] = rx_byte;
					if (pos_q == POS_W'(HEAD_LEN + CENT_HI_OFS))
						cent_d[15:8] = rx_byte;
					if (pos_q == POS_W'(HEAD_LEN + INTS_LO_OFS))
						ints_d[7:0] = rx_byte;
					if (pos_q == POS_W'(HEAD_LEN + INTS_HI_OFS))
						ints_d[15:8] = rx_byte;
					// The check bytes are counted here and never compared.
					if (pos_next < total) begin
						pos_d = pos_next[POS_W-1:0];
					end else begin
						pos_d    = POS_W'(POS_HDR);
						evt.emit = (cmd_q == MEAS_CMD) && (len_q >= LEN_W'(MIN_MEAS_LEN));
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cmd_q    <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			cent_q   <= '0;
			ints_q   <= '0;
		end else begin
			pos_q    <= pos_d;
			cmd_q    <= cmd_d;
			len_hi_q <= len_hi_d;
			len_q    <= len_d;
			cent_q   <= cent_d;
			ints_q   <= ints_d;
		end
	end

endmodule

[hdl/lrfp_range_out.sv]
// Distance conversion, range check and the result register.
module lrfp_range_out
	import lrfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  frame_evt_t        evt,
	input  logic [MAXD_W-1:0] max_dist,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [OUT_W-1:0]  m_tdata
);

	logic [RAW_W+15:0] prod;
	logic [DIST_W-1:0] cm;
	logic              ok;
	logic              valid_q;
	logic [OUT_W-1:0]  data_q;

	// Divide by ten through the reciprocal multiply.
	assign prod = evt.raw * DIV10_MUL;
	assign cm   = prod[DIV10_SHIFT +: DIST_W];
	assign ok   = (evt.raw != '0) && (evt.raw != RAW_INVALID) && (cm != '0)
		&& (MAXD_W'(cm) <= max_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire && evt.emit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && evt.emit) begin
			data_q <= {2'b00, ok ? evt.strength : {STR_W{1'b0}},
				ok ? cm : {DIST_W{1'b0}}, ok};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

[hdl/lrfp_checker.sv]
// Port-level checks for the lidar range frame parser, bound to the top level.
module lrfp_checker
	import lrfp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// An invalid measurement carries zero distance and strength.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
		else $error("invalid result with nonzero fields");

	// A valid measurement has a distance of at least one centimeter.
	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[DIST_W:1] != '0)
		else $error("valid result with zero distance");

	// The converted distance never exceeds the 16-bit raw range over ten.
	a_dist_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> int'(m_tdata[DIST_W:1]) <= DIST_LIMIT)
		else $error("distance beyond conversion range");

	// With the result register empty the input side is never stalled.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

bind lidar_range_frame_parser_unit lrfp_checker u_lrfp_checker (.*);
